/* hdl/gf_pkg.sv */
// ---------------------------------------------------------------------------
// gf_pkg
// Shared widths, operation codes and reset values for the GF(2^8) unit.
// ---------------------------------------------------------------------------
package gf_pkg;

	localparam int ELEM_W     = 8;
	localparam int POLY_W     = 9;
	localparam int KIND_W     = 3;
	localparam int TABLE_DEPTH = 256;

	localparam logic [POLY_W-1:0] POLY_RESET = 9'h11D;

	typedef enum logic [KIND_W-1:0] {
		KIND_ADD = 3'd0,
		KIND_MUL = 3'd1,
		KIND_EXP = 3'd2,
		KIND_LOG = 3'd3,
		KIND_INV = 3'd4
	} kind_t;

endpackage

/* hdl/gf_if.sv */
// ---------------------------------------------------------------------------
// gf_if
// Valid/ready channels of the GF(2^8) unit: request, response, polynomial.
// ---------------------------------------------------------------------------
interface gf_req_if import gf_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [ELEM_W-1:0] operand_a;
	logic [ELEM_W-1:0] operand_b;

	modport source (output valid, kind, operand_a, operand_b, input ready);
	modport sink   (input valid, kind, operand_a, operand_b, output ready);
endinterface

interface gf_rsp_if import gf_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ELEM_W-1:0] value;
	logic              error;

	modport source (output valid, value, error, input ready);
	modport sink   (input valid, value, error, output ready);
endinterface

interface gf_cfg_if import gf_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [POLY_W-1:0] field_polynomial;

	modport source (output valid, field_polynomial, input ready);
	modport sink   (input valid, field_polynomial, output ready);
endinterface

/* hdl/gf_ram.sv */
// ---------------------------------------------------------------------------
// gf_ram
// Generic single-write, single-read RAM with registered, enabled read.
// ---------------------------------------------------------------------------
module gf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hdl/gf256_arithmetic_unit.sv */
// A request passes through stages s1, s2 and s3 before its response appears on rsp.
// Throughput: one request per cycle; a response not taken holds the whole pipeline.
// The log and antilog tables sit in RAMs; the antilog read depends on the log read,
// which sets the three stages.
// After reset and after each polynomial write the tables are rebuilt: ST_CLEAR clears the log
// table and writes antilog, then ST_FILL writes log; req.ready is low during the rebuild.
// ---------------------------------------------------------------------------
// gf256_arithmetic_unit
// GF(2^8) add, multiply, exp, log and inverse through log/antilog tables.
// ---------------------------------------------------------------------------
module gf256_arithmetic_unit import gf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	gf_req_if.sink    req,
	gf_rsp_if.source  rsp,
	gf_cfg_if.sink    cfg
);

	localparam int AW = $clog2(TABLE_DEPTH);

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_FILL  = 3'b010,
		ST_READY = 3'b100
	} state_t;

	state_t            state_q;
	logic [AW-1:0]     cnt_q;
	logic [ELEM_W-1:0] x_q;
	logic [ELEM_W-1:0] poly_q;
	logic [ELEM_W-1:0] x_next;

	logic              alog_we;
	logic              log_we;
	logic [AW-1:0]     log_waddr;
	logic [ELEM_W-1:0] log_wdata;

	logic adv;

	// Stage 1: log reads in flight
	logic              valid_s1;
	logic [KIND_W-1:0] kind_s1;
	logic [ELEM_W-1:0] a_s1;
	logic [ELEM_W-1:0] b_s1;
	logic [ELEM_W-1:0] log_a;
	logic [ELEM_W-1:0] log_b;

	// Stage 2: antilog read in flight
	logic              valid_s2;
	logic [KIND_W-1:0] kind_s2;
	logic [ELEM_W-1:0] a_s2;
	logic [ELEM_W-1:0] b_s2;
	logic [ELEM_W-1:0] la_s2;
	logic [ELEM_W-1:0] alog_raddr;
	logic [ELEM_W:0]   log_sum;
	logic [ELEM_W-1:0] alog_rdata;

	// Stage 3: output register
	logic              valid_s3;
	logic [ELEM_W-1:0] value_s3;
	logic              error_s3;
	logic [ELEM_W-1:0] value_d;
	logic              error_d;

	// ---------------- table build ----------------
	assign x_next = {x_q[ELEM_W-2:0], 1'b0} ^ (x_q[ELEM_W-1] ? poly_q : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q   <= '0;
			x_q     <= ELEM_W'(1);
			poly_q  <= POLY_RESET[ELEM_W-1:0];
		end else if (cfg.valid) begin
			// restart the build with the new polynomial
			state_q <= ST_CLEAR;
			cnt_q   <= '0;
			x_q     <= ELEM_W'(1);
			poly_q  <= cfg.field_polynomial[ELEM_W-1:0];
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					cnt_q <= cnt_q + AW'(1);
					if (cnt_q == AW'(TABLE_DEPTH - 1)) begin
						state_q <= ST_FILL;
						x_q     <= ELEM_W'(1);
					end else begin
						x_q <= x_next;
					end
				end
				ST_FILL: begin
					x_q <= x_next;
					if (cnt_q == AW'(TABLE_DEPTH - 2)) begin
						state_q <= ST_READY;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + AW'(1);
					end
				end
				ST_READY: begin
					cnt_q <= cnt_q;
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	assign cfg.ready = 1'b1;

	assign alog_we   = (state_q == ST_CLEAR);
	assign log_we    = (state_q == ST_CLEAR) || (state_q == ST_FILL);
	assign log_waddr = (state_q == ST_FILL) ? x_q : cnt_q;
	assign log_wdata = (state_q == ST_FILL) ? cnt_q : '0;

	// ---------------- pipeline ----------------
	assign adv       = !valid_s3 || rsp.ready;
	assign req.ready = adv && (state_q == ST_READY);

	// two log copies so multiply reads both operands at once
	gf_ram #(.WIDTH(ELEM_W), .DEPTH(TABLE_DEPTH)) u_log_a (
		.clk   (clk),
		.we    (log_we),
		.waddr (log_waddr),
		.wdata (log_wdata),
		.re    (adv),
		.raddr (req.operand_a),
		.rdata (log_a)
	);

	gf_ram #(.WIDTH(ELEM_W), .DEPTH(TABLE_DEPTH)) u_log_b (
		.clk   (clk),
		.we    (log_we),
		.waddr (log_waddr),
		.wdata (log_wdata),
		.re    (adv),
		.raddr (req.operand_b),
		.rdata (log_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= req.valid && req.ready;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s1  <= req.kind;
			a_s1     <= req.operand_a;
			b_s1     <= req.operand_b;
			kind_s2  <= kind_s1;
			a_s2     <= a_s1;
			b_s2     <= b_s1;
			la_s2    <= log_a;
			value_s3 <= value_d;
			error_s3 <= error_d;
		end
	end

	// end-around carry folds the exponent sum back into 0..255
	assign log_sum = {1'b0, log_a} + {1'b0, log_b};

	always_comb begin
		case (kind_s1)
			KIND_MUL: alog_raddr = log_sum[ELEM_W-1:0] + ELEM_W'(log_sum[ELEM_W]);
			KIND_INV: alog_raddr = ~log_a;
			default:  alog_raddr = a_s1;
		endcase
	end

	gf_ram #(.WIDTH(ELEM_W), .DEPTH(TABLE_DEPTH)) u_alog (
		.clk   (clk),
		.we    (alog_we),
		.waddr (cnt_q),
		.wdata (x_q),
		.re    (adv),
		.raddr (alog_raddr),
		.rdata (alog_rdata)
	);

	always_comb begin
		value_d = '0;
		error_d = 1'b0;
		unique case (kind_s2)
			KIND_ADD: value_d = a_s2 ^ b_s2;
			KIND_MUL: value_d = (a_s2 == '0 || b_s2 == '0) ? '0 : alog_rdata;
			KIND_EXP: value_d = alog_rdata;
			KIND_LOG: begin
				if (a_s2 == '0) error_d = 1'b1;
				else            value_d = la_s2;
			end
			KIND_INV: begin
				if (a_s2 == '0) error_d = 1'b1;
				else            value_d = alog_rdata;
			end
			default:  error_d = 1'b1;
		endcase
	end

	assign rsp.valid = valid_s3;
	assign rsp.value = value_s3;
	assign rsp.error = error_s3;

endmodule
